// ----- rtl/chr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and helper functions of the hash ring
package chr_pkg;

   localparam int RING_ENTRIES_DEF     = 64;
   localparam int VIRTUAL_PER_NODE_DEF = 4;
   localparam int NAME_BYTES_MAX_DEF   = 32;

   localparam int HASH_W  = 32;
   localparam int ID_W    = 32;
   localparam int COUNT_W = 7;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_NAME   = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef struct packed {
      op_type              operation;
      logic [7:0]          data_byte;
      logic                last_byte;
      logic [ID_W-1:0]     node_id;
      logic                node_eligible;
      logic [HASH_W-1:0]   search_key;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     owner_id;
      logic [COUNT_W-1:0]  entry_count;
      logic                entries_dropped;
   } rsp_type;

   // insert command broadcast to every cell
   typedef struct packed {
      logic                en;
      logic [HASH_W-1:0]   hash;
      logic [ID_W-1:0]     owner;
   } ins_type;

   // lookup match flag and owner, merged up the or-tree
   typedef struct packed {
      logic                found;
      logic [ID_W-1:0]     owner;
   } leaf_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_VHASH,
      ST_INSERT,
      ST_WAIT,
      ST_DONE
   } state_type;

   // one fnv-1a round
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      fnv_step = (h ^ {{(HASH_W-8){1'b0}}, b}) * FNV_PRIME;
   endfunction

   // tree level lvl (root is 0) gets a register every third level and at the root
   function automatic bit tree_stage(input int levels, input int lvl);
      tree_stage = (((levels - lvl) % 3) == 0) || (lvl == 0);
   endfunction

   function automatic int tree_latency(input int levels);
      int n;
      n = 0;
      for (int l = 0; l < levels; l++) begin
         if (tree_stage(levels, l)) begin
            n = n + 1;
         end
      end
      tree_latency = n;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/chr_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one ring slot: holds an entry, shifts on sorted insert, flags lookup match
module chr_cell import chr_pkg::*; #(
   parameter int INDEX  = 0,
   parameter int FILL_W = 7
) (
   input  wire logic              clock,
   input  wire ins_type           ins,
   input  wire logic [HASH_W-1:0] lookup_key,
   input  wire logic [FILL_W-1:0] fill,
   input  wire logic              prev_occ,
   input  wire logic [HASH_W-1:0] prev_hash,
   input  wire logic [ID_W-1:0]   prev_owner,
   input  wire logic              prev_ge,
   output logic                   occ,
   output logic [HASH_W-1:0]      hash,
   output logic [ID_W-1:0]        owner,
   output logic                   ge,
   output leaf_type               leaf
);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [ID_W-1:0]   owner_ff, owner_in;
   leaf_type          leaf_ff, leaf_in;
   logic              prev_gt, self_gt;

   assign occ     = fill > FILL_W'(INDEX);
   assign prev_gt = prev_occ & (prev_hash > ins.hash);
   assign self_gt = occ & (hash_ff > ins.hash);

   // neighbor larger: shift up; first slot larger or free: take new entry
   always_comb begin
      hash_in  = hash_ff;
      owner_in = owner_ff;
      if (ins.en) begin
         if (prev_gt) begin
            hash_in  = prev_hash;
            owner_in = prev_owner;
         end else if (!occ || self_gt) begin
            hash_in  = ins.hash;
            owner_in = ins.owner;
         end
      end
   end

   // ring is sorted, so only the first slot at or above the key matches
   assign ge            = occ & (hash_ff >= lookup_key);
   assign leaf_in.found = ge & !prev_ge;
   assign leaf_in.owner = leaf_in.found ? owner_ff : '0;

   always_ff @(posedge clock) begin
      hash_ff  <= hash_in;
      owner_ff <= owner_in;
      leaf_ff  <= leaf_in;
   end

   assign hash  = hash_ff;
   assign owner = owner_ff;
   assign leaf  = leaf_ff;

endmodule
`default_nettype wire

// ----- rtl/chr_or_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
// registered or-tree that collects the single matching cell
module chr_or_tree import chr_pkg::*; #(
   parameter int LEAVES = RING_ENTRIES_DEF
) (
   input  wire logic     clock,
   input  wire leaf_type leaves [LEAVES],
   output leaf_type      root
);

   localparam int LEVELS = $clog2(LEAVES);
   localparam int SPAN   = 1 << LEVELS;

   leaf_type node [1:2*SPAN-1];

   for (genvar k = 0; k < SPAN; k++) begin : g_leaf
      if (k < LEAVES) begin : g_used
         assign node[SPAN+k] = leaves[k];
      end else begin : g_pad
         assign node[SPAN+k] = '0;
      end
   end

   for (genvar k = 1; k < SPAN; k++) begin : g_node
      localparam int LVL = $clog2(k + 1) - 1;
      leaf_type merged;
      assign merged.found = node[2*k].found | node[2*k+1].found;
      assign merged.owner = node[2*k].owner | node[2*k+1].owner;
      if (tree_stage(LEVELS, LVL)) begin : g_reg
         leaf_type merged_ff;
         always_ff @(posedge clock) begin
            merged_ff <= merged;
         end
         assign node[k] = merged_ff;
      end else begin : g_comb
         assign node[k] = merged;
      end
   end

   assign root = node[1];

endmodule
`default_nettype wire

// ----- rtl/consistent_hash_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none
// consistent hash ring: fnv-1a node hashing, sorted slot chain, ring lookup
//
// requests come in on req_valid/req_ready with one req_type payload; every
// request gives exactly one response on rsp_valid/rsp_ready (rsp_type)
// a clear empties the ring and restarts the name hash
// a name byte folds into the running fnv-1a hash; an eligible last byte then
// makes VIRTUAL_PER_NODE entries, one shared hash multiplier round and one
// slot-chain shift per entry, until the ring is full
// a lookup compares the key in every slot at once, then a registered or-tree
// brings the first slot at or above the key to the root; if none is found, the
// answer wraps to slot 0, or is zero on an empty ring
// clear, plain name byte, ineligible last byte and code 3 go from exec to done;
// an eligible last byte adds a hash round, then one insert step per entry;
// a lookup waits out the registered cells and or-tree (2 tree stages for 64 slots)
// the response shows in the same cycle the block turns ready again
// one request is in flight at a time; the response sits in an output register,
// so a stalled receiver holds the block in its final state only until the
// register frees up, and a new request is taken while the response waits
// reset empties the ring and restarts the name hash; slot contents are never
// cleared, slots at or above the fill count are simply ignored
module consistent_hash_ring import chr_pkg::*; #(
   parameter int RING_ENTRIES     = RING_ENTRIES_DEF,
   parameter int VIRTUAL_PER_NODE = VIRTUAL_PER_NODE_DEF,
   parameter int NAME_BYTES_MAX   = NAME_BYTES_MAX_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int FILL_W     = $clog2(RING_ENTRIES + 1);
   localparam int LEN_W      = $clog2(NAME_BYTES_MAX);
   localparam int VIDX_W     = $clog2(VIRTUAL_PER_NODE + 1);
   localparam int TREE_L     = $clog2(RING_ENTRIES);
   localparam int REG_LEVELS = tree_latency(TREE_L);
   localparam int LAT_W      = $clog2(REG_LEVELS + 1);

   // control and datapath registers
   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [HASH_W-1:0] name_hash_ff, name_hash_in;
   logic [LEN_W-1:0]  name_len_ff, name_len_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [VIDX_W-1:0] vidx_ff, vidx_in;
   logic [HASH_W-1:0] vh_ff, vh_in;
   logic [LAT_W-1:0]  lat_ff, lat_in;
   logic [ID_W-1:0]   res_owner_ff, res_owner_in;
   logic              res_drop_ff, res_drop_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // shared hash round
   logic [7:0]        mul_byte;
   logic [HASH_W-1:0] mul_out;

   // slot chain
   ins_type           ins;
   logic              occ_a   [RING_ENTRIES];
   logic [HASH_W-1:0] hash_a  [RING_ENTRIES];
   logic [ID_W-1:0]   owner_a [RING_ENTRIES];
   logic              ge_a    [RING_ENTRIES];
   leaf_type          leaf_a  [RING_ENTRIES];
   leaf_type          root;

   assign mul_byte = (state_ff == ST_VHASH)  ? 8'd0 :
                     (state_ff == ST_INSERT) ? 8'(VIDX_W'(vidx_ff + VIDX_W'(1))) :
                                               req_ff.data_byte;
   assign mul_out  = fnv_step(name_hash_ff, mul_byte);

   // cell 0 has no lower neighbor
   for (genvar i = 0; i < RING_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_first
         chr_cell #(.INDEX(i), .FILL_W(FILL_W)) u_cell (
            .clock      (clock),
            .ins        (ins),
            .lookup_key (req_ff.search_key),
            .fill       (fill_ff),
            .prev_occ   (1'b0),
            .prev_hash  ({HASH_W{1'b0}}),
            .prev_owner ({ID_W{1'b0}}),
            .prev_ge    (1'b0),
            .occ        (occ_a[i]),
            .hash       (hash_a[i]),
            .owner      (owner_a[i]),
            .ge         (ge_a[i]),
            .leaf       (leaf_a[i])
         );
      end else begin : g_rest
         chr_cell #(.INDEX(i), .FILL_W(FILL_W)) u_cell (
            .clock      (clock),
            .ins        (ins),
            .lookup_key (req_ff.search_key),
            .fill       (fill_ff),
            .prev_occ   (occ_a[i-1]),
            .prev_hash  (hash_a[i-1]),
            .prev_owner (owner_a[i-1]),
            .prev_ge    (ge_a[i-1]),
            .occ        (occ_a[i]),
            .hash       (hash_a[i]),
            .owner      (owner_a[i]),
            .ge         (ge_a[i]),
            .leaf       (leaf_a[i])
         );
      end
   end

   chr_or_tree #(.LEAVES(RING_ENTRIES)) u_tree (
      .clock  (clock),
      .leaves (leaf_a),
      .root   (root)
   );

   assign req_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      name_hash_in = name_hash_ff;
      name_len_in  = name_len_ff;
      fill_in      = fill_ff;
      vidx_in      = vidx_ff;
      vh_in        = vh_ff;
      lat_in       = lat_ff;
      res_owner_in = res_owner_ff;
      res_drop_in  = res_drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & !rsp_ready;
      ins.en       = 1'b0;
      ins.hash     = vh_ff;
      ins.owner    = req_ff.node_id;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_owner_in = '0;
            res_drop_in  = 1'b0;
            state_in     = ST_DONE;
            unique case (req_ff.operation)
               OP_CLEAR: begin
                  fill_in      = '0;
                  name_hash_in = FNV_BASIS;
                  name_len_in  = '0;
               end
               OP_NAME: begin
                  // bytes after the first NAME_BYTES_MAX - 1 leave the hash alone
                  if (name_len_ff < LEN_W'(NAME_BYTES_MAX - 1)) begin
                     name_hash_in = mul_out;
                     name_len_in  = LEN_W'(name_len_ff + LEN_W'(1));
                  end
                  if (req_ff.last_byte) begin
                     if (req_ff.node_eligible) begin
                        state_in = ST_VHASH;
                     end else begin
                        name_hash_in = FNV_BASIS;
                        name_len_in  = '0;
                     end
                  end
               end
               OP_LOOKUP: begin
                  lat_in   = '0;
                  state_in = ST_WAIT;
               end
               default: begin
               end
            endcase
         end
         ST_VHASH: begin
            vh_in    = mul_out;
            vidx_in  = '0;
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (fill_ff >= FILL_W'(RING_ENTRIES)) begin
               // ring full: the rest of this node's entries are lost
               res_drop_in  = 1'b1;
               name_hash_in = FNV_BASIS;
               name_len_in  = '0;
               state_in     = ST_DONE;
            end else begin
               ins.en  = 1'b1;
               fill_in = FILL_W'(fill_ff + FILL_W'(1));
               vh_in   = mul_out;
               if (vidx_ff == VIDX_W'(VIRTUAL_PER_NODE - 1)) begin
                  name_hash_in = FNV_BASIS;
                  name_len_in  = '0;
                  state_in     = ST_DONE;
               end else begin
                  vidx_in = VIDX_W'(vidx_ff + VIDX_W'(1));
               end
            end
         end
         ST_WAIT: begin
            lat_in = LAT_W'(lat_ff + LAT_W'(1));
            if (lat_ff == LAT_W'(REG_LEVELS)) begin
               // no slot at or above the key: wrap to the first slot
               if (root.found) begin
                  res_owner_in = root.owner;
               end else if (fill_ff != '0) begin
                  res_owner_in = owner_a[0];
               end else begin
                  res_owner_in = '0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.owner_id        = res_owner_ff;
               rsp_in.entry_count     = COUNT_W'(fill_ff);
               rsp_in.entries_dropped = res_drop_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_hash_ff <= FNV_BASIS;
         name_len_ff  <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         name_hash_ff <= name_hash_in;
         name_len_ff  <= name_len_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      vidx_ff      <= vidx_in;
      vh_ff        <= vh_in;
      lat_ff       <= lat_in;
      res_owner_ff <= res_owner_in;
      res_drop_ff  <= res_drop_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ring never grows past its slot count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RING_ENTRIES))
      else $error("ring fill above capacity");

   // a shift into the chain needs a free slot
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ins.en |-> (fill_ff < FILL_W'(RING_ENTRIES)))
      else $error("insert into a full ring");

   // one request at a time
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while one is in flight");

   // an empty ring never names an owner
   a_empty_owner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && fill_ff == '0) |-> (res_owner_ff == '0))
      else $error("owner reported for empty ring");

endmodule
`default_nettype wire

// ----- bench/consistent_hash_ring_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for the consistent hash ring: directed table, then random node episodes
module consistent_hash_ring_test import chr_pkg::*;;

   // unused operation code, the block must answer it without touching the ring
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 550;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   consistent_hash_ring uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the ring, kept in step with every accepted request
   logic [HASH_W-1:0] ring_hash_q  [RING_ENTRIES_DEF];
   logic [ID_W-1:0]   ring_owner_q [RING_ENTRIES_DEF];
   int                ring_fill = 0;
   logic [HASH_W-1:0] name_acc = FNV_BASIS;
   int                name_bytes = 0;

   rsp_type owed_answers [$];
   rsp_type oldest_answer;
   int      mismatches = 0;

   // run statistics
   int sent_total = 0;
   int n_lookups = 0;
   int n_names = 0;
   int n_drops = 0;
   int ring_peak = 0;

   // sender and receiver pacing
   int next_gap = 0;
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   int rx_hold = 0;
   int idle_cycles = 0;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type fixed;
   } script_row;

   script_row script [$];

   function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      return (h ^ {24'd0, b}) * FNV_PRIME;
   endfunction

   // advance the shadow ring by one request and return its answer
   function automatic rsp_type ring_apply(input req_type r);
      rsp_type           ans;
      logic [HASH_W-1:0] vh;
      int                pos;
      ans = '0;
      case (r.operation)
         OP_CLEAR: begin
            ring_fill = 0;
            name_acc = FNV_BASIS;
            name_bytes = 0;
         end
         OP_NAME: begin
            // bytes after the first NAME_BYTES_MAX_DEF - 1 are not hashed
            if (name_bytes < NAME_BYTES_MAX_DEF - 1) begin
               name_acc = fnv_fold(name_acc, r.data_byte);
               name_bytes++;
            end
            if (r.last_byte) begin
               if (r.node_eligible) begin
                  for (int v = 0; v < VIRTUAL_PER_NODE_DEF && !ans.entries_dropped; v++) begin
                     if (ring_fill >= RING_ENTRIES_DEF) begin
                        ans.entries_dropped = 1'b1;
                     end else begin
                        vh = fnv_fold(name_acc, 8'(v));
                        // equal hashes stay in arrival order
                        pos = ring_fill;
                        while (pos > 0 && ring_hash_q[pos-1] > vh) begin
                           ring_hash_q[pos] = ring_hash_q[pos-1];
                           ring_owner_q[pos] = ring_owner_q[pos-1];
                           pos--;
                        end
                        ring_hash_q[pos] = vh;
                        ring_owner_q[pos] = r.node_id;
                        ring_fill++;
                     end
                  end
               end
               name_acc = FNV_BASIS;
               name_bytes = 0;
            end
         end
         OP_LOOKUP: begin
            // first entry at or above the key, else wrap to entry zero
            if (ring_fill != 0) begin
               ans.owner_id = ring_owner_q[0];
               for (int i = ring_fill - 1; i >= 0; i--) begin
                  if (ring_hash_q[i] >= r.search_key) begin
                     ans.owner_id = ring_owner_q[i];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      ans.entry_count = COUNT_W'(ring_fill);
      return ans;
   endfunction

   function automatic script_row row(input op_type op, input logic [7:0] b,
                                     input logic last, input logic [ID_W-1:0] id,
                                     input logic elig, input logic [HASH_W-1:0] key,
                                     input bit typed, input logic [ID_W-1:0] owner,
                                     input logic [COUNT_W-1:0] count);
      script_row s;
      s.req.operation = op;
      s.req.data_byte = b;
      s.req.last_byte = last;
      s.req.node_id = id;
      s.req.node_eligible = elig;
      s.req.search_key = key;
      s.typed = typed;
      s.fixed.owner_id = owner;
      s.fixed.entry_count = count;
      s.fixed.entries_dropped = 1'b0;
      return s;
   endfunction

   // every field random, callers then set what matters
   function automatic req_type scramble();
      logic [95:0] raw;
      req_type     r;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      return r;
   endfunction

   function automatic req_type lookup_req();
      req_type r;
      int      sel;
      r = scramble();
      r.operation = OP_LOOKUP;
      sel = $urandom_range(0, 5);
      if (ring_fill != 0 && sel < 3) begin
         // land on, just below or just above a live entry
         r.search_key = ring_hash_q[$urandom_range(0, ring_fill - 1)] + 32'(sel) - 32'd1;
      end else if (sel == 3) begin
         r.search_key = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ns  %s: got %h, expected %h", $time, what, got, want);
      end
   endtask

   // drive one request, wait for its handshake and record what it must answer
   task automatic send(input req_type r, input bit typed, input rsp_type fixed);
      rsp_type want;
      repeat (next_gap) @(negedge clock);
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      want = ring_apply(r);
      owed_answers.push_back(typed ? fixed : want);
      sent_total++;
      if (r.operation == OP_LOOKUP) n_lookups++;
      if (r.operation == OP_NAME && r.last_byte) n_names++;
      if (want.entries_dropped) n_drops++;
      if (ring_fill > ring_peak) ring_peak = ring_fill;
      @(negedge clock);
      next_gap = tx_calm ? 0 : $urandom_range(0, 9);
      if (next_gap != 0) req_valid <= 1'b0;
   endtask

   // drop valid and let the block drain every outstanding response
   task automatic hold_off();
      if (next_gap == 0) req_valid <= 1'b0;
      do @(negedge clock); while (owed_answers.size() != 0);
   endtask

   task automatic noise();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         r = lookup_req();
      end else begin
         r = scramble();
         // a clear here cuts a name short
         r.operation = (pick == 9) ? OP_CLEAR : op_type'(OP_RESERVED);
      end
      send(r, 1'b0, '0);
   endtask

   // stream a batch of node names with lookups in between
   task automatic play_episode(input int nodes, input bit all_eligible, input bit first_long);
      req_type         r;
      int              len;
      bit              collide;
      logic [ID_W-1:0] id;
      logic            elig;
      for (int n = 0; n < nodes; n++) begin
         // one-letter names from a tiny alphabet give equal hashes
         collide = ($urandom_range(0, 3) == 0);
         if (n == 0 && first_long) len = 40;
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(30, 40);
         else if (collide) len = 1;
         else len = $urandom_range(1, 6);
         id = $urandom;
         elig = all_eligible || ($urandom_range(0, 6) != 0);
         for (int b = 0; b < len; b++) begin
            r = scramble();
            r.operation = OP_NAME;
            r.data_byte = collide ? 8'(8'h41 + $urandom_range(0, 2)) : 8'($urandom);
            r.last_byte = (b == len - 1);
            if (r.last_byte) begin
               r.node_id = id;
               r.node_eligible = elig;
            end
            send(r, 1'b0, '0);
            if (!r.last_byte && $urandom_range(0, 24) == 0) noise();
         end
         repeat ($urandom_range(0, 2)) send(lookup_req(), 1'b0, '0);
         if ($urandom_range(0, 19) == 0) noise();
      end
   endtask

   // response side: check in order, then hold ready low for a random stall
   always @(posedge clock) begin
      if (reset) begin
         rx_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_answers.size() == 0) begin
               flag_mismatch("response with no request outstanding", rsp_payload.owner_id, '0);
            end else begin
               oldest_answer = owed_answers.pop_front();
               if (rsp_payload.owner_id !== oldest_answer.owner_id)
                  flag_mismatch("owner_id", rsp_payload.owner_id, oldest_answer.owner_id);
               if (rsp_payload.entry_count !== oldest_answer.entry_count)
                  flag_mismatch("entry_count", 32'(rsp_payload.entry_count),
                                32'(oldest_answer.entry_count));
               if (rsp_payload.entries_dropped !== oldest_answer.entries_dropped)
                  flag_mismatch("entries_dropped", 32'(rsp_payload.entries_dropped),
                                32'(oldest_answer.entries_dropped));
            end
            if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
            rx_hold <= rx_calm ? 0 : $urandom_range(0, 9);
         end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && (rx_hold == 0);
   end

   // watchdog: too long without any handshake means the block is stuck
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("consistent_hash_ring: mismatch");
            $finish;
         end
      end
   end

   initial begin
      req_type r;
      int      episode;

      // empty ring, reserved code, first node, ineligible node, equal hashes, clear
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0000_0000, 1, 32'h0, 7'd0));
      script.push_back(row(OP_LOOKUP, 8'hFF, 1'b1, '1, 1'b1, 32'hFFFF_FFFF, 1, 32'h0, 7'd0));
      script.push_back(row(op_type'(OP_RESERVED), 8'hFF, 1'b1, '1, 1'b1, '1, 1, 32'h0, 7'd0));
      script.push_back(row(OP_NAME, 8'h00, 1'b0, 32'h0, 1'b1, 32'h0, 1, 32'h0, 7'd0));
      script.push_back(row(OP_NAME, 8'hFF, 1'b1, '1, 1'b1, 32'h0, 1, 32'h0, 7'd4));
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0000_0000, 0, 32'h0, 7'd0));
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'hFFFF_FFFF, 0, 32'h0, 7'd0));
      script.push_back(row(OP_NAME, 8'h6E, 1'b1, 32'h1234_5678, 1'b0, 32'h0, 1, 32'h0, 7'd4));
      script.push_back(row(OP_NAME, 8'hFF, 1'b1, 32'h0000_0000, 1'b1, 32'h0, 1, 32'h0, 7'd8));
      script.push_back(row(OP_NAME, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1, 32'h0, 7'd8));
      script.push_back(row(OP_NAME, 8'hFF, 1'b1, 32'hA5A5_A5A5, 1'b1, 32'h0, 1, 32'h0, 7'd12));
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'h8000_0000, 0, 32'h0, 7'd0));
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'h7FFF_FFFF, 0, 32'h0, 7'd0));
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0000_0001, 0, 32'h0, 7'd0));
      script.push_back(row(OP_NAME, 8'h78, 1'b0, 32'h0, 1'b1, 32'h0, 1, 32'h0, 7'd12));
      script.push_back(row(OP_CLEAR, 8'hFF, 1'b1, '1, 1'b1, '1, 1, 32'h0, 7'd0));
      script.push_back(row(OP_NAME, 8'h79, 1'b1, 32'h5A5A_5A5A, 1'b1, 32'h0, 1, 32'h0, 7'd4));
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0000_0001, 0, 32'h0, 7'd0));
      script.push_back(row(op_type'(OP_RESERVED), 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1, 32'h0,
                           7'd4));
      script.push_back(row(OP_CLEAR, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1, 32'h0, 7'd0));
      script.push_back(row(OP_LOOKUP, 8'h00, 1'b0, 32'h0, 1'b0, 32'h1234_5678, 1, 32'h0, 7'd0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         send(script[i].req, script[i].typed, script[i].fixed);
      end

      // random episodes; the first one fills the ring past capacity with a long name first
      episode = 0;
      while (sent_total < RANDOM_ITEMS) begin
         if (episode % 5 == 0) hold_off();
         tx_calm = ($urandom_range(0, 3) == 0);
         if (episode == 0 || $urandom_range(0, 9) != 0) begin
            r = scramble();
            r.operation = OP_CLEAR;
            send(r, 1'b0, '0);
         end
         play_episode((episode == 0) ? 18 : $urandom_range(1, 20), episode == 0, episode == 0);
         episode++;
      end

      hold_off();
      repeat (40) @(posedge clock);

      $display("covered %0d requests in %0d episodes: %0d lookups, %0d node names",
               sent_total, episode, n_lookups, n_names);
      $display("ring peaked at %0d entries, %0d names lost entries to a full ring",
               ring_peak, n_drops);
      if (mismatches == 0) begin
         $display("consistent_hash_ring: match");
      end else begin
         $display("consistent_hash_ring: mismatch");
      end
      $finish;
   end

endmodule
